### rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Types and constants shared by the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int IDX_W  = 8;
	localparam int COMP_W = 8;
	localparam int WIDE_W = 16;
	localparam int ENTRY_W = 3 * COMP_W;
	localparam int SQ_W   = 2 * COMP_W;
	localparam int DIST_W = SQ_W + 2;

	// Component positions inside a stored entry
	localparam int SEL_RED   = 2;
	localparam int SEL_GREEN = 1;
	localparam int SEL_BLUE  = 0;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 1'd1;

	localparam logic [IDX_W-1:0] FIRST_RST = 8'd0;
	localparam logic [IDX_W-1:0] LAST_RST  = 8'd254;

	typedef struct packed {
		logic             vld;
		logic             head;
		logic             tail;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} npcs_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} npcs_state_t;

endpackage

### rtl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module npcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell
// One distance cell: adds the squared difference of one color component
// to the partial distance and hands entry, tag and sum to the next cell.
// ----------------------------------------------------------------------------
module npcs_cell import npcs_pkg::*; #(
	parameter int SEL = SEL_RED
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [COMP_W-1:0]  want,
	input  npcs_tag_t          tag_i,
	input  logic [ENTRY_W-1:0] entry_i,
	input  logic [DIST_W-1:0]  psum_i,
	output npcs_tag_t          tag_o,
	output logic [ENTRY_W-1:0] entry_o,
	output logic [DIST_W-1:0]  psum_o
);

	logic [COMP_W-1:0]  want_q;
	npcs_tag_t          tag_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [DIST_W-1:0]  psum_q;
	logic [COMP_W-1:0]  comp;
	logic [COMP_W-1:0]  diff;
	logic [SQ_W-1:0]    sq;

	assign comp = entry_i[SEL*COMP_W +: COMP_W];
	assign diff = (comp >= want_q) ? (comp - want_q) : (want_q - comp);
	assign sq   = SQ_W'(diff) * SQ_W'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			want_q <= want;
		end
		entry_q <= entry_i;
		psum_q  <= psum_i + DIST_W'(sq);
	end

	assign tag_o   = tag_q;
	assign entry_o = entry_q;
	assign psum_o  = psum_q;

endmodule

### rtl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with a nearest color search over first_index..last_index.
// A query of N = last - first + 1 entries reads them in turn; if first > last
// the scan is skipped and first_index is returned.
// Throughput: one entry per cycle through the RAM read port and 3-cell chain.
// Reset clears control and config (first 0, last 254); palette is not cleared.
// ----------------------------------------------------------------------------
module nearest_palette_color_search import npcs_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IDX_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic [WIDE_W-1:0]    entry_red,
	input  logic [WIDE_W-1:0]    entry_green,
	input  logic [WIDE_W-1:0]    entry_blue,
	input  logic [COMP_W-1:0]    want_red,
	input  logic [COMP_W-1:0]    want_green,
	input  logic [COMP_W-1:0]    want_blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     best_index
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	npcs_state_t        state_q, state_d;
	logic [IDX_W-1:0]   first_index_q, last_index_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   res_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DIST_W-1:0]  best_d_q;

	logic               in_acc, wr_acc, qry_acc;
	logic               wr_hit, rd_hit, empty_rng;
	logic               issue, out_load, take;
	logic [IDX_W-1:0]   nxt_idx;
	logic [ENTRY_W-1:0] ram_rdata, entry_s1;
	npcs_tag_t          tag_s1, tag_s2, tag_s3, tag_s4;
	logic [ENTRY_W-1:0] entry_s2, entry_s3, entry_s4;
	logic [DIST_W-1:0]  psum_s2, psum_s3, psum_s4;

	assign in_acc    = in_valid && !in_stall;
	assign wr_acc    = in_acc && (cmd == CMD_WRITE);
	assign qry_acc   = in_acc && (cmd == CMD_QUERY);
	assign wr_hit    = ({24'd0, entry_index} < 32'(PALETTE_ENTRIES));
	assign rd_hit    = ({24'd0, cnt_q} < 32'(PALETTE_ENTRIES));
	assign empty_rng = (first_index_q > last_index_q);
	assign issue     = (state_q == ST_SCAN);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	npcs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_acc && wr_hit),
		.waddr (AW'(entry_index)),
		.wdata ({entry_red[WIDE_W-1 -: COMP_W], entry_green[WIDE_W-1 -: COMP_W],
			entry_blue[WIDE_W-1 -: COMP_W]}),
		.raddr (AW'(cnt_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld  <= issue;
			tag_s1.head <= (cnt_q == first_index_q);
			tag_s1.tail <= (cnt_q == last_index_q);
			tag_s1.hit  <= rd_hit;
			tag_s1.idx  <= cnt_q;
		end
	end

	// slots beyond the store read as black
	assign entry_s1 = tag_s1.hit ? ram_rdata : '0;

	npcs_cell #(.SEL(SEL_RED)) u_cell_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (qry_acc),
		.want    (want_red),
		.tag_i   (tag_s1),
		.entry_i (entry_s1),
		.psum_i  ('0),
		.tag_o   (tag_s2),
		.entry_o (entry_s2),
		.psum_o  (psum_s2)
	);

	npcs_cell #(.SEL(SEL_GREEN)) u_cell_g (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (qry_acc),
		.want    (want_green),
		.tag_i   (tag_s2),
		.entry_i (entry_s2),
		.psum_i  (psum_s2),
		.tag_o   (tag_s3),
		.entry_o (entry_s3),
		.psum_o  (psum_s3)
	);

	npcs_cell #(.SEL(SEL_BLUE)) u_cell_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (qry_acc),
		.want    (want_blue),
		.tag_i   (tag_s3),
		.entry_i (entry_s3),
		.psum_i  (psum_s3),
		.tag_o   (tag_s4),
		.entry_o (entry_s4),
		.psum_o  (psum_s4)
	);

	// strict less keeps the lowest index on ties
	assign take    = tag_s4.vld && (tag_s4.head || (psum_s4 < best_d_q));
	assign nxt_idx = take ? tag_s4.idx : best_idx_q;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (qry_acc) begin
					state_d = empty_rng ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == last_index_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tag_s4.vld && tag_s4.tail) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			first_index_q <= FIRST_RST;
			last_index_q  <= LAST_RST;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST: first_index_q <= cfg_data;
					CFG_LAST:  last_index_q  <= cfg_data;
					default: ;
				endcase
			end
			if (qry_acc) begin
				cnt_q <= first_index_q;
			end else if (issue && (cnt_q != last_index_q)) begin
				cnt_q <= cnt_q + 8'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= tag_s4.idx;
			best_d_q   <= psum_s4;
		end
		if (qry_acc) begin
			res_q <= first_index_q;
		end else if (tag_s4.vld && tag_s4.tail) begin
			res_q <= nxt_idx;
		end
		if (out_load) begin
			out_idx_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = out_idx_q;

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result appeared without a finished search");

	a_tail_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s4.vld && tag_s4.tail) |-> (state_q == ST_DRAIN))
		else $error("last entry left the chain outside drain");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((cnt_q >= first_index_q) && (cnt_q <= last_index_q)))
		else $error("scan index outside the search range");

	a_res_not_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (res_q >= first_index_q))
		else $error("result below first index");

endmodule

### sim/tb_nearest_palette_color_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search
// Drives palette writes and color queries through the valid/stall handshake.
// A behavioral palette and search model predicts each unpinned best_index. A
// directed table covers component extremes, ties, the top slots, empty and
// single-entry ranges. Random phases then refill the palette and sweep search
// ranges, with sender and receiver idling that changes between phase groups.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search;
	import npcs_pkg::*;

	localparam int SLOTS         = 256;
	localparam int PHASES        = 12;
	localparam int PHASE_BEATS   = 64;
	localparam int WRITE_SETTLE  = 8;
	localparam int TAIL_CYCLES   = 300;
	localparam int REPORT_LIMIT  = 10;
	localparam int RUN_LIMIT_NS  = 20_000_000;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  slot;
		logic [WIDE_W-1:0] red;
		logic [WIDE_W-1:0] green;
		logic [WIDE_W-1:0] blue;
		logic [COMP_W-1:0] want_r;
		logic [COMP_W-1:0] want_g;
		logic [COMP_W-1:0] want_b;
	} palette_beat_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_SPAN
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		palette_beat_t    beat;
		bit               pinned;
		logic [IDX_W-1:0] pin;
		logic [IDX_W-1:0] span_lo;
		logic [IDX_W-1:0] span_hi;
	} plan_row_t;

	typedef enum int {
		PACE_LIGHT_SENDER,
		PACE_LIGHT_RECEIVER,
		PACE_STEADY
	} pace_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [IDX_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 cmd;
	logic [IDX_W-1:0]     entry_index;
	logic [WIDE_W-1:0]    entry_red;
	logic [WIDE_W-1:0]    entry_green;
	logic [WIDE_W-1:0]    entry_blue;
	logic [COMP_W-1:0]    want_red;
	logic [COMP_W-1:0]    want_green;
	logic [COMP_W-1:0]    want_blue;
	logic                 out_valid;
	logic                 out_stall;
	logic [IDX_W-1:0]     best_index;

	logic                 beat_pinned;
	logic [IDX_W-1:0]     beat_pin;

	logic [ENTRY_W-1:0]   swatch [SLOTS];
	logic [IDX_W-1:0]     span_first = FIRST_RST;
	logic [IDX_W-1:0]     span_last  = LAST_RST;
	logic [IDX_W-1:0]     best_due [$];
	int                   faults;
	int                   send_gap_pct;
	int                   stall_pct;

	nearest_palette_color_search #(
		.PALETTE_ENTRIES(SLOTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.entry_index(entry_index),
		.entry_red  (entry_red),
		.entry_green(entry_green),
		.entry_blue (entry_blue),
		.want_red   (want_red),
		.want_green (want_green),
		.want_blue  (want_blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_index (best_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("nearest_palette_color_search verification failed");
		$finish;
	end

	function automatic int unsigned color_distance(input int slot, input logic [COMP_W-1:0] r,
			input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		int er;
		int eg;
		int eb;
		er = 0;
		eg = 0;
		eb = 0;
		if (slot < SLOTS) begin
			er = swatch[slot][SEL_RED * COMP_W +: COMP_W];
			eg = swatch[slot][SEL_GREEN * COMP_W +: COMP_W];
			eb = swatch[slot][SEL_BLUE * COMP_W +: COMP_W];
		end
		return (int'(r) - er) * (int'(r) - er) + (int'(g) - eg) * (int'(g) - eg)
			+ (int'(b) - eb) * (int'(b) - eb);
	endfunction

	function automatic logic [IDX_W-1:0] nearest_slot(input logic [COMP_W-1:0] r,
			input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		logic [IDX_W-1:0] best;
		int unsigned      best_d;
		int unsigned      d;
		best = span_first;
		best_d = color_distance(int'(span_first), r, g, b);
		for (int i = int'(span_first); i <= int'(span_last); i++) begin
			d = color_distance(i, r, g, b);
			if (d < best_d) begin
				best_d = d;
				best = i[IDX_W-1:0];
			end
		end
		return best;
	endfunction

	// track config and palette, queue one expected index per accepted query
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST: span_first = cfg_data;
					CFG_LAST:  span_last  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE) begin
					if (int'(entry_index) < SLOTS)
						swatch[entry_index] = {entry_red[WIDE_W-1 -: COMP_W],
							entry_green[WIDE_W-1 -: COMP_W], entry_blue[WIDE_W-1 -: COMP_W]};
				end else if (beat_pinned) begin
					best_due.push_back(beat_pin);
				end else begin
					best_due.push_back(nearest_slot(want_red, want_green, want_blue));
				end
			end
		end
	end

	always @(posedge clk) begin
		logic [IDX_W-1:0] due;
		if (arst_n && out_valid && !out_stall) begin
			if (best_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("unexpected beat: best_index %0d", best_index);
			end else begin
				due = best_due.pop_front();
				if (best_index !== due) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display("mismatch: best_index expected %0d got %0d", due, best_index);
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	function automatic plan_row_t row_span(input int lo, input int hi);
		plan_row_t row;
		row = '{kind: ROW_SPAN, beat: '0, pinned: 1'b0, pin: '0, span_lo: lo[IDX_W-1:0],
			span_hi: hi[IDX_W-1:0]};
		return row;
	endfunction

	function automatic plan_row_t row_paint(input int slot, input logic [WIDE_W-1:0] r,
			input logic [WIDE_W-1:0] g, input logic [WIDE_W-1:0] b);
		plan_row_t row;
		row = '{kind: ROW_BEAT, beat: '0, pinned: 1'b0, pin: '0, span_lo: '0, span_hi: '0};
		row.beat.cmd = CMD_WRITE;
		row.beat.slot = slot[IDX_W-1:0];
		row.beat.red = r;
		row.beat.green = g;
		row.beat.blue = b;
		return row;
	endfunction

	function automatic plan_row_t row_query(input logic [COMP_W-1:0] r,
			input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		plan_row_t row;
		row = '{kind: ROW_BEAT, beat: '0, pinned: 1'b0, pin: '0, span_lo: '0, span_hi: '0};
		row.beat.cmd = CMD_QUERY;
		row.beat.want_r = r;
		row.beat.want_g = g;
		row.beat.want_b = b;
		return row;
	endfunction

	function automatic plan_row_t row_query_pinned(input logic [COMP_W-1:0] r,
			input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b, input int pin);
		plan_row_t row;
		row = row_query(r, g, b);
		row.pinned = 1'b1;
		row.pin = pin[IDX_W-1:0];
		return row;
	endfunction

	function automatic palette_beat_t random_beat();
		palette_beat_t b;
		b.cmd = ($urandom_range(0, 99) < 40) ? CMD_WRITE : CMD_QUERY;
		b.slot = IDX_W'($urandom_range(0, SLOTS - 1));
		b.red = WIDE_W'($urandom);
		b.green = WIDE_W'($urandom);
		b.blue = WIDE_W'($urandom);
		b.want_r = COMP_W'($urandom);
		b.want_g = COMP_W'($urandom);
		b.want_b = COMP_W'($urandom);
		return b;
	endfunction

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_LIGHT_SENDER: begin
				send_gap_pct = 12;
				stall_pct = 45;
			end
			PACE_LIGHT_RECEIVER: begin
				send_gap_pct = 45;
				stall_pct = 12;
			end
			default: begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic issue_beat(input palette_beat_t b, input bit pinned,
			input logic [IDX_W-1:0] pin);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= b.cmd;
		entry_index <= b.slot;
		entry_red <= b.red;
		entry_green <= b.green;
		entry_blue <= b.blue;
		want_red <= b.want_r;
		want_green <= b.want_g;
		want_blue <= b.want_b;
		beat_pinned <= pinned;
		beat_pin <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold off until every query has answered and a trailing write has landed
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (best_due.size() != 0)
			@(posedge clk);
		repeat (WRITE_SETTLE) @(posedge clk);
	endtask

	task automatic set_span(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
		settle_block();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CFG_LAST;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		plan_row_t     directed_plan [$];
		palette_beat_t b;
		int            lo;
		int            hi;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIRST;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_WRITE;
		entry_index = '0;
		entry_red = '0;
		entry_green = '0;
		entry_blue = '0;
		want_red = '0;
		want_green = '0;
		want_blue = '0;
		beat_pinned = 1'b0;
		beat_pin = '0;
		faults = 0;
		set_pace(PACE_LIGHT_SENDER);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_plan = '{
			row_span(0, 3),
			row_paint(0, 16'h0000, 16'h0000, 16'h0000),
			row_paint(1, 16'hffff, 16'hffff, 16'hffff),
			row_paint(2, 16'h12ff, 16'h00ff, 16'h8000),
			row_paint(3, 16'hff00, 16'hff00, 16'hff00),
			row_query_pinned(8'h00, 8'h00, 8'h00, 0),
			row_query_pinned(8'hff, 8'hff, 8'hff, 1),
			row_query_pinned(8'h12, 8'h00, 8'h80, 2),
			row_query(8'h80, 8'h80, 8'h80),
			row_query(8'h10, 8'h00, 8'h70),
			row_paint(255, 16'hffff, 16'h0000, 16'h00ff),
			row_paint(254, 16'h00ff, 16'hff00, 16'h0000),
			row_span(254, 255),
			row_query_pinned(8'hff, 8'h00, 8'h00, 255),
			row_query_pinned(8'h00, 8'hff, 8'h00, 254),
			row_span(255, 254),
			row_query_pinned(8'h00, 8'h00, 8'h00, 255),
			row_span(3, 0),
			row_query_pinned(8'ha5, 8'h5a, 8'h3c, 3),
			row_span(0, 0),
			row_query_pinned(8'h11, 8'h22, 8'h33, 0)
		};
		foreach (directed_plan[k]) begin
			if (directed_plan[k].kind == ROW_SPAN)
				set_span(directed_plan[k].span_lo, directed_plan[k].span_hi);
			else
				issue_beat(directed_plan[k].beat, directed_plan[k].pinned, directed_plan[k].pin);
		end

		// fill every slot so any later range reads written entries only
		for (int n = 0; n < SLOTS; n++) begin
			b = random_beat();
			b.cmd = CMD_WRITE;
			b.slot = n[IDX_W-1:0];
			issue_beat(b, 1'b0, '0);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_pace(p < 4 ? PACE_LIGHT_SENDER : (p < 8 ? PACE_LIGHT_RECEIVER : PACE_STEADY));
			case (p)
				0: begin
					lo = 0;
					hi = SLOTS - 1;
				end
				3: begin
					lo = SLOTS - 1;
					hi = 0;
				end
				5: begin
					lo = FIRST_RST;
					hi = LAST_RST;
				end
				7: begin
					lo = $urandom_range(1, SLOTS - 1);
					hi = $urandom_range(0, lo - 1);
				end
				10: begin
					lo = SLOTS - 1;
					hi = SLOTS - 1;
				end
				11: begin
					lo = 0;
					hi = 0;
				end
				default: begin
					lo = $urandom_range(0, SLOTS - 1);
					hi = lo + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
						: $urandom_range(0, 15));
					if (hi > SLOTS - 1)
						hi = SLOTS - 1;
				end
			endcase
			set_span(lo[IDX_W-1:0], hi[IDX_W-1:0]);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n == PHASE_BEATS / 2 || $urandom_range(0, 99) == 0)
					settle_block();
				issue_beat(random_beat(), 1'b0, '0);
			end
		end

		settle_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		faults += best_due.size();
		if (faults == 0)
			$display("nearest_palette_color_search verification clean");
		else
			$display("nearest_palette_color_search verification failed");
		$finish;
	end

endmodule

### sim.f
rtl/npcs_pkg.sv
rtl/npcs_ram.sv
rtl/npcs_cell.sv
rtl/nearest_palette_color_search.sv
sim/tb_nearest_palette_color_search.sv
